// ----- rtl/core/prle_pkg.sv -----
`timescale 1ns / 1ps

package prle_pkg;

  localparam int PIXEL_W    = 8;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 6;
  localparam int POS_W      = 16;
  localparam int MAX_RUN_DEF    = 63;
  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic [POS_W-1:0]  LINE_WIDTH_RST = 16'd320;
  localparam logic [BYTE_W-1:0] COUNT_BASE     = 8'd192;

  // one or two closed runs produced by a single pixel
  typedef struct packed {
    logic               a_valid;
    logic [PIXEL_W-1:0] a_value;
    logic [LEN_W-1:0]   a_len;
    logic               b_valid;
    logic [PIXEL_W-1:0] b_value;
    logic [LEN_W-1:0]   b_len;
  } prle_cmd_t;

endpackage

// ----- rtl/core/pcx_rle_encoder_core.sv -----
`timescale 1ns / 1ps

// PCX-style run-length encoder for 8-bit palette pixels. Pixels come in raster
// order on the s_ stream, one per transaction, with s_tlast marking the last
// pixel of the image. A run closes when the pixel value changes, when it
// reaches MAX_RUN pixels, at the end of each line (line_width pixels, reset
// 320, written through cfg_we/cfg_wdata, which the user must do only while the
// block is idle; the block does not enforce this) or at the end of the image. A
// closed run of length 1 with a value below 192 is sent as that one byte; any
// other run is sent as a count byte (192 plus length) followed by the value.
// Each pixel yields 0 to 4 bytes on the m_ stream, with m_tlast set on the final
// byte belonging to that pixel (a pixel that produces no byte produces no
// m_tlast). The front end takes one pixel per clock as long as its 4-entry run
// queue has room; the back end drains the queue at one byte per clock while
// m_tready is high, through a registered output. So the sustained rate on busy
// images is set by the output port at one byte per cycle. The first byte of a
// pixel passes through the run queue and then the output register. Reset clears
// run state and the line position.
module pcx_rle_encoder_core #(
  parameter int MAX_RUN    = prle_pkg::MAX_RUN_DEF,
  parameter int FIFO_DEPTH = prle_pkg::FIFO_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // line width register
  input  logic                          cfg_we,
  input  logic [prle_pkg::POS_W-1:0]    cfg_wdata,
  // pixel stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] pixel
  input  logic                          s_tlast,   // end_of_image
  // encoded byte stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [7:0] code_byte
  output logic                          m_tlast    // last byte for this pixel
);
  import prle_pkg::*;

  prle_cmd_t q_wr_cmd;
  prle_cmd_t q_rd_cmd;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  // front end: run tracking and line counting
  prle_front #(
    .MAX_RUN   (MAX_RUN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_pixel  (s_tdata),
    .in_eoi    (s_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_wr_cmd)
  );

  // closed runs waiting to be serialized
  prle_fifo #(
    .DEPTH     (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_cmd    (q_wr_cmd),
    .pop       (q_pop),
    .rd_cmd    (q_rd_cmd),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back end: one byte per transaction
  prle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_rd_cmd),
    .head_valid (!q_empty),
    .pop        (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .out_last   (m_tlast)
  );

endmodule

// ----- rtl/core/prle_front.sv -----
`timescale 1ns / 1ps

module prle_front #(
  parameter int MAX_RUN = prle_pkg::MAX_RUN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [prle_pkg::POS_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [prle_pkg::PIXEL_W-1:0]    in_pixel,
  input  logic                            in_eoi,
  input  logic                            q_full,
  output logic                            q_push,
  output prle_pkg::prle_cmd_t             q_cmd
);
  import prle_pkg::*;

  logic [POS_W-1:0]   line_width;
  logic               run_open;
  logic [PIXEL_W-1:0] run_value;
  logic [LEN_W-1:0]   run_length;
  logic [POS_W-1:0]   line_position;

  logic               accept;
  logic               cont;
  logic               flush_prev;
  logic [PIXEL_W-1:0] new_value;
  logic [LEN_W-1:0]   new_len;
  logic [POS_W:0]     pos_inc;
  logic               line_end;
  logic               close_now;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cont       = run_open && (in_pixel == run_value);
    flush_prev = run_open && !cont;
    new_value  = cont ? run_value : in_pixel;
    new_len    = cont ? LEN_W'(run_length + 1'b1) : LEN_W'(1);
    pos_inc    = {1'b0, line_position} + 1'b1;
    line_end   = pos_inc >= {1'b0, line_width};
    close_now  = line_end || (new_len >= LEN_W'(MAX_RUN)) || in_eoi;

    q_cmd.a_valid = flush_prev;
    q_cmd.a_value = run_value;
    q_cmd.a_len   = run_length;
    q_cmd.b_valid = close_now;
    q_cmd.b_value = new_value;
    q_cmd.b_len   = new_len;
    q_push        = accept && (flush_prev || close_now);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RST;
    end else if (cfg_we) begin
      line_width <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open      <= 1'b0;
      run_value     <= '0;
      run_length    <= '0;
      line_position <= '0;
    end else if (accept) begin
      run_open      <= !close_now;
      run_value     <= new_value;
      run_length    <= close_now ? '0 : new_len;
      line_position <= (line_end || in_eoi) ? '0 : pos_inc[POS_W-1:0];
    end
  end

  // end of image flushes the run and restarts the line
  a_eoi_flush: assert property (@(posedge clk) disable iff (rst)
    (accept && in_eoi) |=> (!run_open && line_position == '0))
    else $error("run not flushed at end of image");

  // an open run never reaches the maximum length
  a_run_short: assert property (@(posedge clk) disable iff (rst)
    run_open |-> (run_length < LEN_W'(MAX_RUN) && run_length != '0))
    else $error("open run length out of range");

endmodule

// ----- rtl/core/prle_fifo.sv -----
`timescale 1ns / 1ps

module prle_fifo #(
  parameter int DEPTH = prle_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  prle_pkg::prle_cmd_t wr_cmd,
  input  logic                pop,
  output prle_pkg::prle_cmd_t rd_cmd,
  output logic                full,
  output logic                empty
);
  import prle_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  prle_cmd_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = count == CNT_W'(DEPTH);
  assign empty  = count == '0;
  assign rd_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule

// ----- rtl/core/prle_back.sv -----
`timescale 1ns / 1ps

module prle_back (
  input  logic                          clk,
  input  logic                          rst,
  input  prle_pkg::prle_cmd_t           head,
  input  logic                          head_valid,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [prle_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_last
);
  import prle_pkg::*;

  logic [1:0]        idx;
  logic [1:0]        cnt_a;
  logic [1:0]        cnt_b;
  logic [2:0]        total;
  logic [1:0]        idx_b;
  logic              lit_a;
  logic              lit_b;
  logic [BYTE_W-1:0] byte_sel;
  logic              is_last;
  logic              load;
  logic              emit;

  always_comb begin
    lit_a = (head.a_len == LEN_W'(1)) && (head.a_value < COUNT_BASE);
    lit_b = (head.b_len == LEN_W'(1)) && (head.b_value < COUNT_BASE);
    cnt_a = !head.a_valid ? 2'd0 : (lit_a ? 2'd1 : 2'd2);
    cnt_b = !head.b_valid ? 2'd0 : (lit_b ? 2'd1 : 2'd2);
    total = {1'b0, cnt_a} + {1'b0, cnt_b};
    idx_b = idx - cnt_a;

    // count byte first unless literal, then the value
    if (idx < cnt_a) begin
      byte_sel = (!lit_a && idx == 2'd0) ? COUNT_BASE + BYTE_W'(head.a_len) : head.a_value;
    end else begin
      byte_sel = (!lit_b && idx_b == 2'd0) ? COUNT_BASE + BYTE_W'(head.b_len) : head.b_value;
    end
    is_last = {1'b0, idx} == (total - 3'd1);

    load = !out_valid || out_ready;
    emit = load && head_valid;
    pop  = emit && is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (emit) begin
      out_valid <= 1'b1;
      idx       <= is_last ? 2'd0 : 2'(idx + 1'b1);
    end else if (load) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= byte_sel;
      out_last <= is_last;
    end
  end

  // every queued entry carries at least one run
  a_entry_nonempty: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (total != 3'd0 && {1'b0, idx} < total))
    else $error("queue entry without bytes");

endmodule
